// ===== rtl/core/mctp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctp_pkg
// Shared types, character codes and helper functions for the motion command
// text parser.
// ----------------------------------------------------------------------------
package mctp_pkg;

	localparam logic [7:0] CHAR_B     = 8'h42;
	localparam logic [7:0] CHAR_L     = 8'h4C;
	localparam logic [7:0] CHAR_F     = 8'h46;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;
	localparam logic [7:0] CHAR_COMMA = 8'h2C;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [7:0] CENTRE_RESET = 8'd90;
	localparam logic [1:0] FRAC_MAX     = 2'd3;

	typedef enum logic [1:0] {
		FLD_DIR   = 2'd0,
		FLD_SPEED = 2'd1,
		FLD_ANGLE = 2'd2,
		FLD_TIME  = 2'd3
	} field_t;

	typedef struct packed {
		field_t             fld;
		logic               have_dir;
		logic [7:0]         dir;
		logic               neg;
		logic [31:0]        digit;
		logic [1:0]         frac_cnt;
		logic               in_frac;
		logic               spd_neg;
		logic [15:0]        spd_mag;
		logic signed [15:0] angle;
	} parse_state_t;

	localparam parse_state_t PS_CLEAR = '{
		fld:      FLD_DIR,
		have_dir: 1'b0,
		dir:      8'd0,
		neg:      1'b0,
		digit:    32'd0,
		frac_cnt: 2'd0,
		in_frac:  1'b0,
		spd_neg:  1'b0,
		spd_mag:  16'd0,
		angle:    16'sd0
	};

	// v * 10 + d, saturating at all ones
	function automatic logic [31:0] push_digit(input logic [31:0] v, input logic [3:0] d);
		logic [35:0] t;
		t = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {32'd0, d};
		return (|t[35:32]) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	function automatic logic [15:0] sat_speed(input logic [31:0] v);
		return (|v[31:16]) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic logic signed [15:0] close_angle(input logic neg, input logic [31:0] v);
		logic [16:0] mag;
		logic [16:0] negated;
		if (neg) begin
			mag     = (v > 32'd32768) ? 17'd32768 : v[16:0];
			negated = 17'd0 - mag;
			return negated[15:0];
		end else begin
			return (v > 32'd32767) ? 16'sh7FFF : v[15:0];
		end
	endfunction

	function automatic logic [9:0] frac_scale(input logic [1:0] cnt);
		logic [9:0] s;
		unique case (cnt)
			2'd0: s = 10'd1000;
			2'd1: s = 10'd100;
			2'd2: s = 10'd10;
			default: s = 10'd1;
		endcase
		return s;
	endfunction

endpackage

// ===== rtl/core/mctp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctp_in_if
// Text byte channel: valid/ready handshake with one character per transaction.
// ----------------------------------------------------------------------------
interface mctp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       end_of_text;

	modport source (output valid, output text_byte, output end_of_text, input ready);
	modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// ===== rtl/core/mctp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctp_out_if
// Drive command channel: valid/ready handshake with one command per transaction.
// ----------------------------------------------------------------------------
interface mctp_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         direction_char;
	logic               forwards;
	logic [15:0]        speed_magnitude;
	logic signed [15:0] servo_angle;
	logic [31:0]        step_ms;
	logic [31:0]        end_time_ms;

	modport source (
		output valid, output direction_char, output forwards, output speed_magnitude,
		output servo_angle, output step_ms, output end_time_ms, input ready
	);
	modport sink (
		input valid, input direction_char, input forwards, input speed_magnitude,
		input servo_angle, input step_ms, input end_time_ms, output ready
	);
endinterface

// ===== rtl/core/mctp_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mctp_parser
// Input register and per-byte field parser. A terminator byte hands a snapshot
// of the finished command to the next stage and clears the command state.
// ----------------------------------------------------------------------------
module mctp_parser
	import mctp_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [7:0]   in_byte,
	input  logic         in_eot,
	output logic         snap_valid,
	input  logic         snap_ready,
	output parse_state_t snap
);

	logic         v_s1;
	logic [7:0]   byte_s1;
	logic         eot_s1;
	logic         v_s2;
	parse_state_t snap_s2;
	parse_state_t ps_q;
	parse_state_t nxt;
	logic         en1;
	logic         en2;
	logic         is_slash;
	logic         term;
	logic         is_digit;
	logic [7:0]   dig8;

	assign en2      = !v_s2 || snap_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign is_slash = (byte_s1 == CHAR_SLASH);
	assign term     = is_slash || eot_s1;
	assign is_digit = (byte_s1 >= CHAR_ZERO) && (byte_s1 <= CHAR_NINE);
	assign dig8     = byte_s1 - CHAR_ZERO;

	always_comb begin
		nxt = ps_q;
		if (!is_slash) begin
			if (ps_q.fld == FLD_DIR && !ps_q.have_dir) begin
				nxt.dir      = byte_s1;
				nxt.have_dir = 1'b1;
			end
			priority if (byte_s1 == CHAR_COMMA) begin
				if (ps_q.fld != FLD_TIME) begin
					if (ps_q.fld == FLD_SPEED) begin
						nxt.spd_neg = ps_q.neg;
						nxt.spd_mag = sat_speed(ps_q.digit);
					end else if (ps_q.fld == FLD_ANGLE) begin
						nxt.angle = close_angle(ps_q.neg, ps_q.digit);
					end
					nxt.neg   = 1'b0;
					nxt.digit = 32'd0;
					nxt.fld   = field_t'(2'(ps_q.fld) + 2'd1);
				end
			end else if (ps_q.fld != FLD_DIR) begin
				priority if (is_digit) begin
					if (ps_q.fld == FLD_TIME && ps_q.in_frac) begin
						if (ps_q.frac_cnt != FRAC_MAX) begin
							nxt.digit    = push_digit(ps_q.digit, dig8[3:0]);
							nxt.frac_cnt = ps_q.frac_cnt + 2'd1;
						end
					end else begin
						nxt.digit = push_digit(ps_q.digit, dig8[3:0]);
					end
				end else if (byte_s1 == CHAR_MINUS && ps_q.fld != FLD_TIME) begin
					nxt.neg = 1'b1;
				end else if (byte_s1 == CHAR_DOT && ps_q.fld == FLD_TIME) begin
					nxt.in_frac = 1'b1;
				end else begin
					nxt.in_frac = ps_q.in_frac;
				end
			end else begin
				nxt.neg = ps_q.neg;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			ps_q <= PS_CLEAR;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (v_s1 && en2) begin
				ps_q <= term ? PS_CLEAR : nxt;
			end
			if (en2) begin
				v_s2 <= v_s1 && term;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			byte_s1 <= in_byte;
			eot_s1  <= in_eot;
		end
		if (en2 && v_s1 && term) begin
			snap_s2 <= nxt;
		end
	end

	assign snap_valid = v_s2;
	assign snap       = snap_s2;

endmodule

// ===== rtl/core/motion_command_text_parser_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// motion_command_text_parser_top
// Parses motion command text (dir,speed,angle,seconds separated by '/') into
// drive commands with saturated speed, servo angle, duration and end time.
// A terminator's command passes the input, snapshot, s3 and s4 registers.
// One byte per cycle unless the output stalls, set by the parser state loop.
// Output stage is a register; bubbles collapse, so input keeps flowing while
// a command waits. Reset clears all parse state, end time to 0, centre to 90.
// ----------------------------------------------------------------------------
module motion_command_text_parser_top
	import mctp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	mctp_in_if.sink    in_ch,
	mctp_out_if.source out_ch,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic               snap_valid;
	logic               snap_ready;
	parse_state_t       snap;
	logic [7:0]         centre_q;
	logic               en3;
	logic               en4;

	logic               v_s3;
	logic [7:0]         dir_s3;
	logic               fwd_s3;
	logic [15:0]        mag_s3;
	logic signed [15:0] servo_s3;
	logic [31:0]        step_s3;

	logic               v_s4;
	logic [7:0]         dir_s4;
	logic               fwd_s4;
	logic [15:0]        mag_s4;
	logic signed [15:0] servo_s4;
	logic [31:0]        step_s4;
	logic [31:0]        total_ms_q;

	logic               sneg;
	logic [15:0]        smag;
	logic signed [15:0] ang;
	logic [17:0]        ssum;
	logic [41:0]        prod;
	logic [31:0]        step_c;
	logic [32:0]        tsum;
	logic [31:0]        total_c;

	mctp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_ch.valid),
		.in_ready   (in_ch.ready),
		.in_byte    (in_ch.text_byte),
		.in_eot     (in_ch.end_of_text),
		.snap_valid (snap_valid),
		.snap_ready (snap_ready),
		.snap       (snap)
	);

	assign en4        = !v_s4 || out_ch.ready;
	assign en3        = !v_s3 || en4;
	assign snap_ready = en3;

	always_comb begin
		if (snap.fld == FLD_SPEED) begin
			sneg = snap.neg;
			smag = sat_speed(snap.digit);
		end else begin
			sneg = snap.spd_neg;
			smag = snap.spd_mag;
		end
		if (snap.dir == CHAR_B && !sneg && smag != 16'd0) begin
			sneg = 1'b1;
		end
		ang = (snap.fld == FLD_ANGLE) ? close_angle(snap.neg, snap.digit) : snap.angle;
		if (snap.dir == CHAR_L && ang > 16'sd0) begin
			ang = -ang;
		end else if (snap.dir == CHAR_F || snap.dir == CHAR_B) begin
			ang = 16'sd0;
		end
		ssum = {{2{ang[15]}}, ang} + {10'd0, centre_q};
		prod = 42'(snap.digit) * 42'(frac_scale(snap.frac_cnt));
		if (snap.fld == FLD_TIME) begin
			step_c = (|prod[41:32]) ? 32'hFFFF_FFFF : prod[31:0];
		end else begin
			step_c = 32'd0;
		end
	end

	assign tsum    = {1'b0, total_ms_q} + {1'b0, step_s3};
	assign total_c = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			centre_q   <= CENTRE_RESET;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			total_ms_q <= 32'd0;
		end else begin
			if (cfg_we) begin
				centre_q <= cfg_wdata;
			end
			if (en3) begin
				v_s3 <= snap_valid;
			end
			if (en4) begin
				v_s4 <= v_s3;
			end
			if (en4 && v_s3) begin
				total_ms_q <= total_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && snap_valid) begin
			dir_s3   <= snap.dir;
			fwd_s3   <= !(sneg && smag != 16'd0);
			mag_s3   <= smag;
			servo_s3 <= (!ssum[17] && ssum[16:15] != 2'b00) ? 16'sh7FFF : ssum[15:0];
			step_s3  <= step_c;
		end
		if (en4 && v_s3) begin
			dir_s4   <= dir_s3;
			fwd_s4   <= fwd_s3;
			mag_s4   <= mag_s3;
			servo_s4 <= servo_s3;
			step_s4  <= step_s3;
		end
	end

	assign out_ch.valid           = v_s4;
	assign out_ch.direction_char  = dir_s4;
	assign out_ch.forwards        = fwd_s4;
	assign out_ch.speed_magnitude = mag_s4;
	assign out_ch.servo_angle     = servo_s4;
	assign out_ch.step_ms         = step_s4;
	assign out_ch.end_time_ms     = total_ms_q;

	a_end_ge_step: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> total_ms_q >= step_s4)
		else $error("end time below step duration");

	a_rev_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !fwd_s4) |-> mag_s4 != 16'd0)
		else $error("reverse flag with zero speed");

	a_fwd_centre: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && dir_s4 == CHAR_F) |-> servo_s4 == {8'd0, centre_q})
		else $error("F command not at servo centre");

	a_back_rev: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && dir_s4 == CHAR_B) |-> (!fwd_s4 || mag_s4 == 16'd0))
		else $error("B command moving forwards");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for motion_command_text_parser_top. A short list of
// hand-checked commands runs first. Random command text follows, well-formed
// commands with stray bytes mixed in plus pure noise, at several servo
// centre settings. Every drive command leaving the block is compared field by
// field against the hand-checked value for the listed commands, or else
// against a cycle-free parser model kept inside the bench. Both sides of the
// byte stream stall at random, and one phase holds the output off long
// enough to back up the input.
module tb;
	import mctp_pkg::*;

	typedef struct packed {
		logic [7:0]         dir;
		logic               fwd;
		logic [15:0]        speed;
		logic signed [15:0] servo;
		logic [31:0]        step;
		logic [31:0]        end_time;
	} drive_cmd_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	mctp_in_if  in_ch();
	mctp_out_if out_ch();

	motion_command_text_parser_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.out_ch   (out_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// parser model state
	field_t      cur_field;
	logic [7:0]  cmd_dir;
	bit          dir_taken;
	bit          minus_seen;
	logic [31:0] accum;
	logic [1:0]  frac_count;
	bit          frac_mode;
	int          speed_val;
	int          angle_val;
	logic [31:0] elapsed_ms;
	logic [7:0]  centre;

	drive_cmd_t  cmds_due[$];
	drive_cmd_t  typed_cmd;
	bit          typed_due;
	int          mismatches;

	bit          src_stalls;
	bit          sink_stalls;
	int          sink_hold;

	logic [7:0]  cmd_text[$];

	string       row_text[$];
	bit          row_eot[$];
	bit          row_typed[$];
	bit          row_late[$];
	drive_cmd_t  row_want[$];

	function void clear_cmd();
		cur_field  = FLD_DIR;
		cmd_dir    = 8'd0;
		dir_taken  = 1'b0;
		minus_seen = 1'b0;
		accum      = '0;
		frac_count = 2'd0;
		frac_mode  = 1'b0;
		speed_val  = 0;
		angle_val  = 0;
	endfunction

	function logic [31:0] times_ten_plus(logic [31:0] v, logic [7:0] c);
		logic [7:0]  d;
		logic [63:0] t;
		d = c - CHAR_ZERO;
		t = 64'(v) * 10 + 64'(d);
		return (t > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
	endfunction

	function void store_field();
		logic [31:0] mag;
		mag = accum;
		if (cur_field == FLD_SPEED) begin
			if (mag > 32'd65535) mag = 32'd65535;
			speed_val = minus_seen ? -int'(mag) : int'(mag);
		end else if (cur_field == FLD_ANGLE) begin
			if (minus_seen) begin
				if (mag > 32'd32768) mag = 32'd32768;
				angle_val = -int'(mag);
			end else begin
				if (mag > 32'd32767) mag = 32'd32767;
				angle_val = int'(mag);
			end
		end
		minus_seen = 1'b0;
		accum = '0;
	endfunction

	function void take_char(logic [7:0] c);
		if (cur_field == FLD_DIR && !dir_taken) begin
			cmd_dir = c;
			dir_taken = 1'b1;
		end
		if (c == CHAR_COMMA) begin
			if (cur_field != FLD_TIME) begin
				store_field();
				cur_field = field_t'(cur_field + 2'd1);
			end
		end else if (cur_field != FLD_DIR) begin
			if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
				if (cur_field != FLD_TIME || !frac_mode) begin
					accum = times_ten_plus(accum, c);
				end else if (frac_count < FRAC_MAX) begin
					accum = times_ten_plus(accum, c);
					frac_count = frac_count + 2'd1;
				end
			end else if (c == CHAR_MINUS && cur_field != FLD_TIME) begin
				minus_seen = 1'b1;
			end else if (c == CHAR_DOT && cur_field == FLD_TIME) begin
				frac_mode = 1'b1;
			end
		end
	endfunction

	function drive_cmd_t finish_cmd();
		drive_cmd_t  r;
		logic [63:0] prod;
		logic [63:0] scale;
		logic [31:0] dur;
		int          spd;
		int          ang;
		int          servo;
		dur = '0;
		if (cur_field == FLD_TIME) begin
			case (frac_count)
				2'd0: scale = 1000;
				2'd1: scale = 100;
				2'd2: scale = 10;
				default: scale = 1;
			endcase
			prod = 64'(accum) * scale;
			dur = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
		end else begin
			store_field();
		end
		spd = speed_val;
		ang = angle_val;
		if (cmd_dir == CHAR_B && spd > 0) spd = -spd;
		if (cmd_dir == CHAR_L && ang > 0) ang = -ang;
		else if (cmd_dir == CHAR_F || cmd_dir == CHAR_B) ang = 0;
		servo = ang + int'({24'd0, centre});
		if (servo > 32767) servo = 32767;
		if (servo < -32768) servo = -32768;
		prod = 64'(elapsed_ms) + 64'(dur);
		elapsed_ms = (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
		r.dir      = cmd_dir;
		r.fwd      = (spd >= 0);
		r.speed    = 16'((spd < 0) ? -spd : spd);
		r.servo    = 16'(servo);
		r.step     = dur;
		r.end_time = elapsed_ms;
		clear_cmd();
		return r;
	endfunction

	task automatic report(input string msg);
		$display("ERROR %0t ns: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [63:0] got,
			input logic [63:0] want);
		if (got !== want) report($sformatf("%s got %0h want %0h", name, got, want));
	endtask

	function int idle_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	function void put_digits(int n);
		repeat (n) cmd_text.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
	endfunction

	function void add_row(bit late, string text, bit eot, bit typed, drive_cmd_t want);
		row_late.push_back(late);
		row_text.push_back(text);
		row_eot.push_back(eot);
		row_typed.push_back(typed);
		row_want.push_back(want);
	endfunction

	always @(posedge clk) begin : cmd_check
		drive_cmd_t cmd;
		drive_cmd_t want;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			if (in_ch.text_byte != CHAR_SLASH) take_char(in_ch.text_byte);
			if (in_ch.text_byte == CHAR_SLASH || in_ch.end_of_text) begin
				cmd = finish_cmd();
				if (typed_due) begin
					cmd = typed_cmd;
					typed_due = 1'b0;
				end
				cmds_due.push_back(cmd);
			end
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (cmds_due.size() == 0) begin
				report("drive command with none outstanding");
			end else begin
				want = cmds_due.pop_front();
				check_field("direction_char", out_ch.direction_char, want.dir);
				check_field("forwards", out_ch.forwards, want.fwd);
				check_field("speed_magnitude", out_ch.speed_magnitude, want.speed);
				check_field("servo_angle", $unsigned(out_ch.servo_angle), $unsigned(want.servo));
				check_field("step_ms", out_ch.step_ms, want.step);
				check_field("end_time_ms", out_ch.end_time_ms, want.end_time);
			end
		end
	end

	initial begin : sink_side
		int stall;
		stall = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (sink_hold > 0) begin
				out_ch.ready <= 1'b0;
				sink_hold--;
			end else if (stall > 0) begin
				out_ch.ready <= 1'b0;
				stall--;
			end else begin
				out_ch.ready <= 1'b1;
				if (sink_stalls && $urandom_range(0, 3) == 0) stall = idle_len();
			end
		end
	end

	task automatic send_byte(input logic [7:0] c, input bit eot, input bit typed,
			input drive_cmd_t want);
		int gap;
		gap = (src_stalls && $urandom_range(0, 3) == 0) ? idle_len() : 0;
		repeat (gap) begin
			@(negedge clk);
			in_ch.valid <= 1'b0;
			in_ch.text_byte <= 8'($urandom);
		end
		@(negedge clk);
		in_ch.valid <= 1'b1;
		in_ch.text_byte <= c;
		in_ch.end_of_text <= eot;
		if (typed) begin
			typed_cmd = want;
			typed_due = 1'b1;
		end
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_ch.valid <= 1'b0;
		while (cmds_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic load_centre(input logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		centre = v;
	endtask

	task automatic run_rows(input bit late);
		int n;
		foreach (row_text[i]) begin
			if (row_late[i] == late) begin
				n = row_text[i].len();
				for (int k = 0; k < n; k++)
					send_byte(row_text[i][k], row_eot[i] && k == n - 1,
						row_typed[i] && k == n - 1, row_want[i]);
			end
		end
	endtask

	task automatic send_random(input int target);
		int sent;
		int nf;
		bit eot_end;
		sent = 0;
		while (sent < target) begin
			cmd_text.delete();
			if ($urandom_range(0, 5) == 0) begin
				repeat ($urandom_range(1, 12)) cmd_text.push_back(8'($urandom));
				eot_end = $urandom_range(0, 1);
			end else begin
				case ($urandom_range(0, 6))
					0: cmd_text.push_back(CHAR_F);
					1: cmd_text.push_back(CHAR_B);
					2: cmd_text.push_back(CHAR_L);
					3: cmd_text.push_back("R");
					4: cmd_text.push_back(CHAR_COMMA);
					default: cmd_text.push_back(8'($urandom));
				endcase
				nf = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : 3;
				for (int f = 1; f <= nf; f++) begin
					if (f > 1 || cmd_text[0] != CHAR_COMMA) cmd_text.push_back(CHAR_COMMA);
					if (f < 3) begin
						if ($urandom_range(0, 2) == 0) cmd_text.push_back(CHAR_MINUS);
						put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(5, 11)
							: $urandom_range(0, 3));
					end else begin
						put_digits(($urandom_range(0, 19) == 0) ? 4 : $urandom_range(0, 3));
						if ($urandom_range(0, 1)) begin
							cmd_text.push_back(CHAR_DOT);
							put_digits($urandom_range(0, 5));
						end
					end
					if ($urandom_range(0, 9) == 0) cmd_text.push_back(8'($urandom));
				end
				eot_end = ($urandom_range(0, 5) == 0);
			end
			if (!eot_end) cmd_text.push_back(CHAR_SLASH);
			foreach (cmd_text[i])
				send_byte(cmd_text[i], eot_end && i == cmd_text.size() - 1, 1'b0, '0);
			sent += cmd_text.size();
		end
	endtask

	initial begin : watchdog
		#20ms;
		$display("motion_command_text_parser_top test failed");
		$finish;
	end

	initial begin : stimulus
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.text_byte = 8'd0;
		in_ch.end_of_text = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		src_stalls = 1'b1;
		sink_stalls = 1'b1;
		sink_hold = 0;
		typed_due = 1'b0;
		mismatches = 0;
		centre = CENTRE_RESET;
		elapsed_ms = '0;
		clear_cmd();

		// centre 90 after reset, end time counted from 0
		add_row(0, "/", 0, 1, '{8'h00, 1'b1, 16'd0, 16'sd90, 32'd0, 32'd0});
		add_row(0, "F,100,30,2.5/", 0, 1,
			'{CHAR_F, 1'b1, 16'd100, 16'sd90, 32'd2500, 32'd2500});
		add_row(0, "B,250,45,1/", 0, 1,
			'{CHAR_B, 1'b0, 16'd250, 16'sd90, 32'd1000, 32'd3500});
		add_row(0, "L,80,40,0.25/", 0, 1,
			'{CHAR_L, 1'b1, 16'd80, 16'sd50, 32'd250, 32'd3750});
		add_row(0, "R,-60,-20,3.1234/", 0, 1,
			'{"R", 1'b0, 16'd60, 16'sd70, 32'd3123, 32'd6873});
		add_row(0, "R,65536,32768,1/", 0, 1,
			'{"R", 1'b1, 16'd65535, 16'sd32767, 32'd1000, 32'd7873});
		add_row(0, "R,65535,-32769,0/", 0, 1,
			'{"R", 1'b1, 16'd65535, -16'sd32678, 32'd0, 32'd7873});
		add_row(0, "L,5,-7,0/", 0, 1, '{CHAR_L, 1'b1, 16'd5, 16'sd83, 32'd0, 32'd7873});
		add_row(0, "B,-9,12/", 0, 1, '{CHAR_B, 1'b0, 16'd9, 16'sd90, 32'd0, 32'd7873});
		add_row(0, "R,1-2,3/", 0, 1, '{"R", 1'b0, 16'd12, 16'sd93, 32'd0, 32'd7873});
		add_row(0, ",5,6,7/", 0, 1,
			'{CHAR_COMMA, 1'b1, 16'd5, 16'sd96, 32'd7000, 32'd14873});
		add_row(0, "R,+1x2,3.4,1.2.5,9/", 0, 1,
			'{"R", 1'b1, 16'd12, 16'sd124, 32'd1259, 32'd16132});
		add_row(0, "R,1,2,-3/", 0, 1, '{"R", 1'b1, 16'd1, 16'sd92, 32'd3000, 32'd19132});
		add_row(0, "F,-7,9,1.0005", 1, 1,
			'{CHAR_F, 1'b0, 16'd7, 16'sd90, 32'd1000, 32'd20132});
		add_row(0, "X/", 1, 1, '{"X", 1'b1, 16'd0, 16'sd90, 32'd0, 32'd20132});
		add_row(0, "R,7", 1, 1, '{"R", 1'b1, 16'd7, 16'sd90, 32'd0, 32'd20132});
		add_row(0, "R,3,4,5,6/", 0, 1, '{"R", 1'b1, 16'd3, 16'sd94, 32'd56000, 32'd76132});
		add_row(0, "LEFT,8,9,.5/", 0, 1,
			'{CHAR_L, 1'b1, 16'd8, 16'sd81, 32'd500, 32'd76632});
		add_row(0, "-,1,1,1/", 0, 1,
			'{CHAR_MINUS, 1'b1, 16'd1, 16'sd91, 32'd1000, 32'd77632});
		add_row(0, "\377,2,3,4/", 0, 1, '{8'hFF, 1'b1, 16'd2, 16'sd93, 32'd4000, 32'd81632});
		// saturating times, run last since the end time stays at its ceiling
		add_row(1, "R,0,0,4294967.2955/", 0, 0, '0);
		add_row(1, "R,1,2,99999999999/", 0, 0, '0);
		add_row(1, "B,1,2,3/", 1, 0, '0);

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		run_rows(1'b0);
		drain();

		load_centre(8'd0);
		send_random(240);
		drain();

		load_centre(8'd255);
		src_stalls = 1'b0;
		sink_stalls = 1'b0;
		send_random(190);
		drain();

		// output held off while bytes keep coming, then wait for it to empty
		sink_hold = 400;
		send_random(80);
		drain();

		load_centre(8'($urandom));
		src_stalls = 1'b1;
		sink_stalls = 1'b1;
		send_random(170);
		drain();

		load_centre(8'($urandom));
		sink_stalls = 1'b0;
		send_random(130);
		drain();

		sink_stalls = 1'b1;
		run_rows(1'b1);
		drain();

		if (cmds_due.size() != 0) report($sformatf("%0d drive commands never came",
			cmds_due.size()));
		if (mismatches == 0) begin
			$display("motion_command_text_parser_top test passed");
		end else begin
			$display("motion_command_text_parser_top test failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/mctp_pkg.sv
rtl/core/mctp_in_if.sv
rtl/core/mctp_out_if.sv
rtl/core/mctp_parser.sv
rtl/core/motion_command_text_parser_top.sv
tb/tb.sv
